// ===== rtl/core/ip_range_blocklist_match_assert.svh =====
// Assertion helpers for the address range filter.
`ifndef IP_RANGE_BLOCKLIST_MATCH_ASSERT_SVH
`define IP_RANGE_BLOCKLIST_MATCH_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IPBL_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IPBL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/ipbl_pkg.sv =====
`timescale 1ns / 1ps

package ipbl_pkg;

	localparam int unsigned ENTRIES_W = 7;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_CLEAR  = 2'd1,
		OP_LOOKUP = 2'd2
	} op_e;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WAIT
	} state_e;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] range_low;
		logic [31:0] range_high;
		logic [31:0] address;
	} in_t;

	typedef struct packed {
		logic                 hit;
		logic                 status;
		logic [ENTRIES_W-1:0] entries_used;
	} out_t;

	typedef struct packed {
		logic vld;
		logic hit;
	} tok_t;

endpackage

// ===== rtl/core/ipbl_cell.sv =====
`timescale 1ns / 1ps

module ipbl_cell #(
	parameter int unsigned INDEX = 0,
	parameter int unsigned CW    = 7
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  logic [31:0]    wr_low,
	input  logic [31:0]    wr_high,
	input  logic [CW-1:0]  count,
	input  logic [31:0]    addr,
	input  ipbl_pkg::tok_t tok_in,
	output ipbl_pkg::tok_t tok_out
);

	logic [31:0]    lo_q;
	logic [31:0]    hi_q;
	logic           in_use;
	logic           match;
	ipbl_pkg::tok_t tok_q;

	assign in_use = count > CW'(INDEX);
	assign match  = tok_in.vld && in_use && (addr >= lo_q) && (addr <= hi_q);

	always_ff @(posedge clk) begin
		if (wr_en && (count == CW'(INDEX))) begin
			lo_q <= wr_low;
			hi_q <= wr_high;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q.vld <= tok_in.vld;
			tok_q.hit <= tok_in.hit || match;
		end
	end

	assign tok_out = tok_q;

endmodule

// ===== rtl/core/ip_range_blocklist_match.sv =====
`timescale 1ns / 1ps

// Filters IPv4 addresses against a table of up to MAX_RANGES inclusive ranges held in a row
// of cells, one range per cell. Insert, clear and the unused op code need no scan. A lookup
// sends a token down the row, one cell per clock, and its result is ready once the token
// leaves the last cell. Each result word is loaded into the output register if the output
// is free, else held in a wait state until it is. One input word is worked on at a time,
// and a new one is accepted as soon as the previous result is loaded into the output
// register, even if that result has not yet been taken.
module ip_range_blocklist_match #(
	parameter int unsigned MAX_RANGES = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  ipbl_pkg::in_t   in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output ipbl_pkg::out_t  out_data
);

	localparam int unsigned CW = $clog2(MAX_RANGES + 1);
	localparam int unsigned EW = ipbl_pkg::ENTRIES_W;

	ipbl_pkg::state_e state_q, state_d;
	logic [CW-1:0]    count_q, count_d;
	logic [31:0]      addr_q;
	logic             start_q, start_d;
	ipbl_pkg::out_t   res_q, res_d;
	ipbl_pkg::out_t   out_q;
	logic             out_valid_q;
	ipbl_pkg::out_t   new_res;
	logic             new_vld;
	logic             load_out;
	ipbl_pkg::out_t   load_data;
	logic             wr_en;
	logic             accept;
	logic             out_free;
	logic [CW+EW-1:0] cnt_ext;
	ipbl_pkg::tok_t   tok [MAX_RANGES+1];

	assign in_ready = (state_q == ipbl_pkg::ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	assign tok[0].vld = start_q;
	assign tok[0].hit = 1'b0;

	for (genvar i = 0; i < MAX_RANGES; i++) begin : g_cell
		ipbl_cell #(
			.INDEX (i),
			.CW    (CW)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.wr_en   (wr_en),
			.wr_low  (in_data.range_low),
			.wr_high (in_data.range_high),
			.count   (count_q),
			.addr    (addr_q),
			.tok_in  (tok[i]),
			.tok_out (tok[i+1])
		);
	end

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		start_d   = 1'b0;
		res_d     = res_q;
		new_res   = '0;
		new_vld   = 1'b0;
		load_out  = 1'b0;
		load_data = new_res;
		wr_en     = 1'b0;
		case (state_q)
			ipbl_pkg::ST_IDLE: begin
				if (accept) begin
					case (in_data.op)
						ipbl_pkg::OP_INSERT: begin
							if (count_q < CW'(MAX_RANGES)) begin
								wr_en   = 1'b1;
								count_d = count_q + CW'(1);
							end else begin
								new_res.status = 1'b1;
							end
							new_vld = 1'b1;
						end
						ipbl_pkg::OP_CLEAR: begin
							count_d = '0;
							new_vld = 1'b1;
						end
						ipbl_pkg::OP_LOOKUP: begin
							start_d = 1'b1;
							state_d = ipbl_pkg::ST_SCAN;
						end
						default: begin
							new_vld = 1'b1;
						end
					endcase
				end
			end
			ipbl_pkg::ST_SCAN: begin
				if (tok[MAX_RANGES].vld) begin
					new_res.hit = tok[MAX_RANGES].hit;
					new_vld     = 1'b1;
					state_d     = ipbl_pkg::ST_IDLE;
				end
			end
			ipbl_pkg::ST_WAIT: begin
				if (out_free) begin
					load_out  = 1'b1;
					load_data = res_q;
					state_d   = ipbl_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ipbl_pkg::ST_IDLE;
			end
		endcase

		cnt_ext              = (CW + EW)'(count_d);
		new_res.entries_used = cnt_ext[EW-1:0];

		if (new_vld) begin
			if (out_free) begin
				load_out  = 1'b1;
				load_data = new_res;
			end else begin
				res_d   = new_res;
				state_d = ipbl_pkg::ST_WAIT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ipbl_pkg::ST_IDLE;
			count_q     <= '0;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			start_q <= start_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
		if (accept) begin
			addr_q <= in_data.address;
		end
		if (load_out) begin
			out_q <= load_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`include "ip_range_blocklist_match_assert.svh"

	`IPBL_ASSERT_SAME(a_count_bound, 1'b1, count_q <= CW'(MAX_RANGES), "range count above table size")
	`IPBL_ASSERT_SAME(a_tail_in_scan, tok[MAX_RANGES].vld, state_q == ipbl_pkg::ST_SCAN, "lookup token outside scan")
	`IPBL_ASSERT_SAME(a_wait_holds_out, state_q == ipbl_pkg::ST_WAIT, out_valid_q, "result waiting with free output")
	`IPBL_ASSERT_NEXT(a_insert_counts, wr_en, count_q == $past(count_q) + CW'(1), "insert did not advance count")

endmodule
